// ----- design/fbpc_pkg.sv -----
// Shared types and constants for the five-bit pixel pack codec.
package fbpc_pkg;

  localparam int MAX_RESULTS = 6;
  localparam int SLOT_W      = $clog2(MAX_RESULTS);
  localparam int ACC_W       = 7;
  localparam int CNT_W       = 3;
  localparam int PHASE_W     = 2;
  localparam int WIDE_W      = ACC_W + 8;
  localparam int SUM_W       = CNT_W + 1;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 1;

  localparam logic DIR_PACK   = 1'b0;
  localparam logic DIR_UNPACK = 1'b1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DIRECTION = 1'b0,
    REG_GRAYSCALE = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_frame;
  } sample_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_data;
    logic       last_result;
  } result_t;

  typedef struct packed {
    logic direction;
    logic grayscale_mode;
  } codec_cfg_t;

  typedef struct packed {
    logic [ACC_W-1:0]   acc;
    logic [CNT_W-1:0]   cnt;
    logic [PHASE_W-1:0] phase;
  } codec_state_t;

  // All results caused by one request; entries 0..last_idx are sent in order.
  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] bytes;
    logic [SLOT_W-1:0]           last_idx;
    logic                        has_data;
    logic                        eof;
  } bundle_t;

endpackage

// ----- design/fbpc_core.sv -----
// Single-pass pack/unpack datapath: one request to a bundle of results and next state.
module fbpc_core
  import fbpc_pkg::*;
#(
  parameter int SYMBOL_BITS = 5
) (
  input  codec_cfg_t   cfg,
  input  sample_t      item,
  input  codec_state_t cur,
  output codec_state_t nxt,
  output logic         emit,
  output bundle_t      bundle
);

  localparam int LOW_BITS = 8 - SYMBOL_BITS;
  localparam int MAX_SYMS = (WIDE_W / SYMBOL_BITS);
  localparam logic [WIDE_W-1:0] SYM_MASK = WIDE_W'((1 << SYMBOL_BITS) - 1);

  logic                        take, pack_full, pack_flush;
  logic [WIDE_W-1:0]           pv, uv;
  logic [SUM_W-1:0]            pc, pc_left, uc, ures;
  logic [ACC_W-1:0]            pacc, uacc;
  logic [CNT_W-1:0]            pcnt, ucnt;
  logic [7:0]                  pbyte, fbyte;
  logic [PHASE_W-1:0]          phase_next;
  logic [MAX_RESULTS-1:0]      sym_ok, ent_ok;
  logic [MAX_RESULTS-1:0][7:0] sym_byte, ent_byte;
  logic [SLOT_W-1:0]           last;
  logic                        any;

  // pack path
  always_comb begin
    take      = !cfg.grayscale_mode || (cur.phase == '0);
    pv        = (WIDE_W'(cur.acc) << SYMBOL_BITS) | WIDE_W'(item.data_byte >> LOW_BITS);
    pc        = SUM_W'(cur.cnt) + SUM_W'(SYMBOL_BITS);
    pack_full = take && (pc >= SUM_W'(8));
    pbyte     = 8'(pv >> (pc - SUM_W'(8)));
    pc_left   = pack_full ? pc - SUM_W'(8) : pc;
    if (take) begin
      pacc = ACC_W'(pv & ((WIDE_W'(1) << pc_left) - WIDE_W'(1)));
      pcnt = CNT_W'(pc_left);
    end else begin
      pacc = cur.acc;
      pcnt = cur.cnt;
    end
    // final partial byte is left-aligned, zero padded
    pack_flush = item.end_of_frame && (pcnt != '0);
    fbyte      = 8'(WIDE_W'(pacc) << (SUM_W'(8) - SUM_W'(pcnt)));
    if (!cfg.grayscale_mode) begin
      phase_next = cur.phase;
    end else if (cur.phase >= PHASE_W'(2)) begin
      phase_next = '0;
    end else begin
      phase_next = cur.phase + PHASE_W'(1);
    end
  end

  // unpack path: every symbol slot decoded side by side
  always_comb begin
    uv = {cur.acc, item.data_byte};
    uc = SUM_W'(cur.cnt) + SUM_W'(8);
    for (int j = 0; j < MAX_RESULTS; j++) begin
      sym_ok[j]   = int'(uc) >= (j + 1) * SYMBOL_BITS;
      sym_byte[j] = 8'((uv >> SUM_W'(int'(uc) - (j + 1) * SYMBOL_BITS)) & SYM_MASK)
                    << LOW_BITS;
    end
    // symbols beyond the result slots are still consumed
    ures = uc;
    for (int j = 1; j <= MAX_SYMS; j++) begin
      if (int'(uc) >= j * SYMBOL_BITS) ures = SUM_W'(int'(uc) - j * SYMBOL_BITS);
    end
    uacc = ACC_W'(uv & ((WIDE_W'(1) << ures) - WIDE_W'(1)));
    ucnt = CNT_W'(ures);
  end

  always_comb begin
    for (int k = 0; k < MAX_RESULTS; k++) begin
      if (cfg.direction == DIR_UNPACK) begin
        if (cfg.grayscale_mode) begin
          ent_ok[k]   = sym_ok[k / 3];
          ent_byte[k] = sym_byte[k / 3];
        end else begin
          ent_ok[k]   = sym_ok[k];
          ent_byte[k] = sym_byte[k];
        end
      end else begin
        ent_ok[k]   = 1'b0;
        ent_byte[k] = '0;
      end
    end
    if (cfg.direction == DIR_PACK) begin
      ent_ok[0]   = pack_full || pack_flush;
      ent_byte[0] = pack_full ? pbyte : fbyte;
      ent_ok[1]   = pack_full && pack_flush;
      ent_byte[1] = fbyte;
    end
    any  = ent_ok[0];
    last = '0;
    for (int k = 1; k < MAX_RESULTS; k++) begin
      if (ent_ok[k]) last = SLOT_W'(k);
    end
  end

  always_comb begin
    emit            = any || item.end_of_frame;
    bundle.bytes    = any ? ent_byte : '0;
    bundle.last_idx = last;
    bundle.has_data = any;
    bundle.eof      = item.end_of_frame;
    if (item.end_of_frame) begin
      nxt = '0;
    end else if (cfg.direction == DIR_PACK) begin
      nxt = '{acc: pacc, cnt: pcnt, phase: phase_next};
    end else begin
      nxt = '{acc: uacc, cnt: ucnt, phase: cur.phase};
    end
  end

endmodule

// ----- design/fbpc_drain.sv -----
// Result bundle register and output register; sends one result per cycle while results are taken.
module fbpc_drain
  import fbpc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    bundle_valid,
  output logic    bundle_ready,
  input  bundle_t bundle,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  logic              held_valid;
  bundle_t           held;
  logic [SLOT_W-1:0] idx;
  logic              out_load, held_done, at_last;

  assign at_last      = (idx == held.last_idx);
  assign out_load     = held_valid && (!result_valid || result_ready);
  assign held_done    = out_load && at_last;
  assign bundle_ready = !held_valid || held_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid   <= 1'b0;
      idx          <= '0;
      result_valid <= 1'b0;
    end else begin
      if (bundle_valid && bundle_ready) begin
        held_valid <= 1'b1;
        held       <= bundle;
        idx        <= '0;
      end else if (held_done) begin
        held_valid <= 1'b0;
      end else if (out_load) begin
        idx <= idx + SLOT_W'(1);
      end

      if (out_load) begin
        result_valid       <= 1'b1;
        result.out_byte    <= held.bytes[idx];
        result.has_data    <= held.has_data;
        result.last_result <= held.eof && at_last;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- design/five_bit_pixel_pack_codec.sv -----
// Five-bit pixel pack codec top level: input register, codec state, config, result drain.
// A request's first result passes the input register, bundle register and output register.
// Throughput: 1 request per cycle while each gives at most one result and output is taken;
// a request giving more results holds the drain until sent (up to 6 in grayscale unpack).
// Reset (rst, synchronous): config and codec state go to zero, all stages empty.
module five_bit_pixel_pack_codec
  import fbpc_pkg::*;
#(
  parameter int SYMBOL_BITS = 5
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   sample_valid,
  output logic                   sample_ready,
  input  sample_t                sample,
  output logic                   result_valid,
  input  logic                   result_ready,
  output result_t                result
);

  codec_cfg_t   cfg;
  codec_state_t cur, nxt;
  logic         in_valid;
  sample_t      in_item;
  logic         core_emit, bundle_ready, advance;
  bundle_t      core_bundle;

  assign advance      = in_valid && (!core_emit || bundle_ready);
  assign sample_ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg      <= '0;
      cur      <= '0;
      in_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (reg_index_t'(cfg_index))
          REG_DIRECTION: cfg.direction      <= cfg_data[0];
          REG_GRAYSCALE: cfg.grayscale_mode <= cfg_data[0];
          default: ;
        endcase
      end
      if (advance) cur <= nxt;
      if (sample_valid && sample_ready) begin
        in_valid <= 1'b1;
        in_item  <= sample;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
    end
  end

  fbpc_core #(
    .SYMBOL_BITS(SYMBOL_BITS)
  ) u_core (
    .cfg    (cfg),
    .item   (in_item),
    .cur    (cur),
    .nxt    (nxt),
    .emit   (core_emit),
    .bundle (core_bundle)
  );

  fbpc_drain u_drain (
    .clk          (clk),
    .rst          (rst),
    .bundle_valid (in_valid && core_emit),
    .bundle_ready (bundle_ready),
    .bundle       (core_bundle),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // end of frame always leaves the codec state cleared
  a_eof_clears: assert property (@(posedge clk) disable iff (rst)
    advance && in_item.end_of_frame |=> cur == '0)
    else $error("codec state not cleared after end of frame");

  // a bare end marker is zero and closes the frame
  a_marker_form: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.has_data |-> result.last_result && (result.out_byte == '0))
    else $error("malformed end marker");

  // packing never yields more than two results per request
  a_pack_two: assert property (@(posedge clk) disable iff (rst)
    in_valid && core_emit && (cfg.direction == DIR_PACK) |-> core_bundle.last_idx <= SLOT_W'(1))
    else $error("pack request produced too many results");

endmodule
